// ----- rtl/core/scalar_kalman_angle_filter_assert.svh -----
// ----------------------------------------------------------------------------
// Scalar Kalman angle filter assertion macros
// Concurrent checks on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_ANGLE_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_ANGLE_FILTER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SKAF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("skaf: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define SKAF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("skaf: next-cycle check failed");

`endif

// ----- rtl/core/skaf_pkg.sv -----
// ----------------------------------------------------------------------------
// skaf_pkg
// Shared widths, register indexes, microcode format and program ROM.
// ----------------------------------------------------------------------------
package skaf_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int DT_BITS       = 16;

    localparam int GAIN_W     = FRACTION_BITS + 1;
    localparam int MUL_A_W    = VALUE_WIDTH + 1;
    localparam int MUL_B_W    = GAIN_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int PMAG_W     = PROD_W - FRACTION_BITS;
    localparam int DIV_W      = VALUE_WIDTH + 2;
    localparam int DIV_CNT_W  = $clog2(FRACTION_BITS);
    localparam int UPC_W      = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [GAIN_W-1:0]      GAIN_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] UNC_RESET = VALUE_WIDTH'(GAIN_ONE);
    localparam logic [31:0]            PN_RESET  = 32'd66;
    localparam logic [31:0]            MN_RESET  = 32'd1966;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

    typedef logic [UPC_W-1:0] upc_t;

    // program addresses
    localparam upc_t UPC_WAIT  = 4'd0;
    localparam upc_t UPC_RATE  = 4'd1;
    localparam upc_t UPC_DELTA = 4'd2;
    localparam upc_t UPC_DIV   = 4'd3;
    localparam upc_t UPC_ERR   = 4'd4;
    localparam upc_t UPC_MCORR = 4'd5;
    localparam upc_t UPC_CORR  = 4'd6;
    localparam upc_t UPC_MUNC  = 4'd7;
    localparam upc_t UPC_UNC   = 4'd8;
    localparam upc_t UPC_SEED  = 4'd9;
    localparam upc_t UPC_OUT   = 4'd10;

    typedef enum logic [1:0] {
        MSEL_RATE,
        MSEL_ERR,
        MSEL_UNC
    } mul_sel_t;

    typedef enum logic [1:0] {
        ANG_HOLD,
        ANG_ADD_RATE,
        ANG_ADD_ERR,
        ANG_SEED
    } ang_sel_t;

    typedef enum logic [2:0] {
        JC_NEXT,    // fall through
        JC_GOTO,    // unconditional jump
        JC_IN,      // hold until a transaction; seed jumps, update falls through
        JC_DIV,     // loop on target until the last quotient bit
        JC_OUT      // hold until the output slot is free, then jump
    } jump_t;

    typedef struct packed {
        logic     in_ready;
        logic     mul_en;
        mul_sel_t mul_sel;
        ang_sel_t ang_sel;
        logic     p_pred_en;
        logic     div_init;
        logic     div_step;
        logic     err_en;
        logic     unc_wr;
        logic     out_load;
        jump_t    jump;
        upc_t     target;
    } ucode_t;

    typedef struct packed {
        logic div_last;
    } dp_status_t;

    function automatic ucode_t ucode_rom(input upc_t upc);
        ucode_t uc;
        uc = '0;
        case (upc)
            UPC_WAIT: begin
                uc.in_ready = 1'b1;
                uc.jump     = JC_IN;
                uc.target   = UPC_SEED;
            end
            UPC_RATE: begin
                uc.mul_en    = 1'b1;
                uc.mul_sel   = MSEL_RATE;
                uc.p_pred_en = 1'b1;
            end
            UPC_DELTA: begin
                uc.ang_sel  = ANG_ADD_RATE;
                uc.div_init = 1'b1;
            end
            UPC_DIV: begin
                uc.div_step = 1'b1;
                uc.jump     = JC_DIV;
                uc.target   = UPC_DIV;
            end
            UPC_ERR: begin
                uc.err_en = 1'b1;
            end
            UPC_MCORR: begin
                uc.mul_en  = 1'b1;
                uc.mul_sel = MSEL_ERR;
            end
            UPC_CORR: begin
                uc.ang_sel = ANG_ADD_ERR;
            end
            UPC_MUNC: begin
                uc.mul_en  = 1'b1;
                uc.mul_sel = MSEL_UNC;
            end
            UPC_UNC: begin
                uc.unc_wr = 1'b1;
                uc.jump   = JC_GOTO;
                uc.target = UPC_OUT;
            end
            UPC_SEED: begin
                uc.ang_sel = ANG_SEED;
            end
            UPC_OUT: begin
                uc.out_load = 1'b1;
                uc.jump     = JC_OUT;
                uc.target   = UPC_WAIT;
            end
            default: begin
                uc.jump   = JC_GOTO;
                uc.target = UPC_WAIT;
            end
        endcase
        return uc;
    endfunction

endpackage

// ----- rtl/core/skaf_sequencer.sv -----
// ----------------------------------------------------------------------------
// skaf_sequencer
// Program counter over the microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module skaf_sequencer
    import skaf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic       in_command,
    input  logic       out_free,
    input  dp_status_t status,
    output ucode_t     ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    upc_t upc_inc;

    assign ctrl    = ucode_rom(upc_reg);
    assign upc_inc = upc_reg + 1'b1;

    always_comb begin
        upc_next = upc_reg;
        case (ctrl.jump)
            JC_NEXT: upc_next = upc_inc;
            JC_GOTO: upc_next = ctrl.target;
            JC_IN: begin
                if (in_accept) begin
                    upc_next = in_command ? ctrl.target : upc_inc;
                end
            end
            JC_DIV:  upc_next = status.div_last ? upc_inc : ctrl.target;
            JC_OUT: begin
                if (out_free) begin
                    upc_next = ctrl.target;
                end
            end
            default: upc_next = UPC_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_WAIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- rtl/core/skaf_datapath.sv -----
// ----------------------------------------------------------------------------
// skaf_datapath
// Filter state, shared multiplier, restoring divider and saturating adder.
// ----------------------------------------------------------------------------
`include "scalar_kalman_angle_filter_assert.svh"

module skaf_datapath
    import skaf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ucode_t                        ctrl,
    input  logic                          in_load,
    input  logic signed [VALUE_WIDTH-1:0] angular_rate,
    input  logic signed [VALUE_WIDTH-1:0] accel_angle,
    input  logic        [DT_BITS-1:0]     time_step,
    input  logic signed [VALUE_WIDTH-1:0] seed_angle,
    input  logic        [VALUE_WIDTH-1:0] process_noise,
    input  logic        [VALUE_WIDTH-1:0] measurement_noise,
    output dp_status_t                    status,
    output logic        [VALUE_WIDTH-1:0] angle
);

    localparam int SUM_W = PMAG_W + 2;

    // captured transaction
    logic                   rate_neg_reg;
    logic [MUL_A_W-1:0]     rmag_reg;
    logic [DT_BITS-1:0]     dt_reg;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] seed_reg;

    // filter state
    logic [VALUE_WIDTH-1:0] angle_reg;
    logic [VALUE_WIDTH-1:0] unc_reg;
    logic [VALUE_WIDTH-1:0] p_reg;

    // divider
    logic [VALUE_WIDTH:0]   d_reg;
    logic [VALUE_WIDTH:0]   rem_reg;
    logic [GAIN_W-1:0]      quo_reg;
    logic                   dzero_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;

    // error and multiplier
    logic                   err_neg_reg;
    logic [MUL_A_W-1:0]     emag_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic signed [VALUE_WIDTH:0] rate_x;
    logic signed [VALUE_WIDTH:0] err_x;
    logic [MUL_A_W-1:0]     rmag_next;
    logic [MUL_A_W-1:0]     emag_next;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [PMAG_W-1:0]      prod_mag;
    logic [GAIN_W-1:0]      gain;
    logic [VALUE_WIDTH:0]   psum;
    logic [VALUE_WIDTH-1:0] p_sat;
    logic [VALUE_WIDTH:0]   d_next;
    logic                   q0;
    logic [DIV_W-1:0]       r2;
    logic                   ge;
    logic                   add_neg;
    logic [SUM_W-1:0]       angle_ext;
    logic [SUM_W-1:0]       mag_ext;
    logic [SUM_W-1:0]       sum;
    logic                   sum_fits;
    logic [VALUE_WIDTH-1:0] sum_sat;
    logic [VALUE_WIDTH-1:0] angle_next;

    assign rate_x    = {angular_rate[VALUE_WIDTH-1], angular_rate};
    assign rmag_next = rate_x[VALUE_WIDTH] ? MUL_A_W'(-rate_x) : MUL_A_W'(rate_x);

    assign err_x     = $signed({acc_reg[VALUE_WIDTH-1], acc_reg})
                     - $signed({angle_reg[VALUE_WIDTH-1], angle_reg});
    assign emag_next = err_x[VALUE_WIDTH] ? MUL_A_W'(-err_x) : MUL_A_W'(err_x);

    assign gain = dzero_reg ? '0 : quo_reg;

    // shared multiplier operands
    always_comb begin
        case (ctrl.mul_sel)
            MSEL_RATE: begin
                mul_a = rmag_reg;
                mul_b = MUL_B_W'(dt_reg);
            end
            MSEL_ERR: begin
                mul_a = emag_reg;
                mul_b = gain;
            end
            MSEL_UNC: begin
                mul_a = {1'b0, p_reg};
                mul_b = GAIN_ONE - gain;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_mag = prod_reg[PROD_W-1:FRACTION_BITS];

    // predicted uncertainty, saturating
    assign psum  = {1'b0, unc_reg} + {1'b0, process_noise};
    assign p_sat = psum[VALUE_WIDTH] ? '1 : psum[VALUE_WIDTH-1:0];

    // divider setup and one quotient bit per step
    assign d_next = {1'b0, p_reg} + {1'b0, measurement_noise};
    assign q0     = ({1'b0, p_reg} >= d_next);
    assign r2     = {rem_reg, 1'b0};
    assign ge     = (r2 >= {1'b0, d_reg});

    assign status.div_last = (div_cnt_reg == DIV_CNT_W'(FRACTION_BITS - 1));

    // saturating angle adder
    assign add_neg   = (ctrl.ang_sel == ANG_ADD_ERR) ? err_neg_reg : rate_neg_reg;
    assign angle_ext = {{(SUM_W - VALUE_WIDTH){angle_reg[VALUE_WIDTH-1]}}, angle_reg};
    assign mag_ext   = {2'b00, prod_mag};
    assign sum       = add_neg ? angle_ext - mag_ext : angle_ext + mag_ext;
    assign sum_fits  = (&sum[SUM_W-1:VALUE_WIDTH-1]) | ~(|sum[SUM_W-1:VALUE_WIDTH-1]);
    assign sum_sat   = sum_fits ? sum[VALUE_WIDTH-1:0]
                     : (sum[SUM_W-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                     : {1'b0, {(VALUE_WIDTH-1){1'b1}}});

    always_comb begin
        case (ctrl.ang_sel)
            ANG_HOLD:     angle_next = angle_reg;
            ANG_ADD_RATE: angle_next = sum_sat;
            ANG_ADD_ERR:  angle_next = sum_sat;
            ANG_SEED:     angle_next = seed_reg;
            default:      angle_next = angle_reg;
        endcase
    end

    assign angle = angle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0;
            unc_reg   <= UNC_RESET;
        end else begin
            angle_reg <= angle_next;
            if (ctrl.unc_wr) begin
                unc_reg <= prod_reg[FRACTION_BITS +: VALUE_WIDTH];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            rate_neg_reg <= rate_x[VALUE_WIDTH];
            rmag_reg     <= rmag_next;
            dt_reg       <= time_step;
            acc_reg      <= accel_angle;
            seed_reg     <= seed_angle;
        end
        if (ctrl.mul_en) begin
            prod_reg <= mul_p;
        end
        if (ctrl.p_pred_en) begin
            p_reg <= p_sat;
        end
        if (ctrl.div_init) begin
            d_reg       <= d_next;
            dzero_reg   <= (d_next == '0);
            rem_reg     <= q0 ? {1'b0, p_reg} - d_next : {1'b0, p_reg};
            quo_reg     <= GAIN_W'(q0);
            div_cnt_reg <= '0;
        end else if (ctrl.div_step) begin
            rem_reg     <= ge ? (VALUE_WIDTH + 1)'(r2 - {1'b0, d_reg}) : r2[VALUE_WIDTH:0];
            quo_reg     <= {quo_reg[FRACTION_BITS-1:0], ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (ctrl.err_en) begin
            err_neg_reg <= err_x[VALUE_WIDTH];
            emag_reg    <= emag_next;
        end
    end

    // gain never exceeds 1.0 once the quotient is complete
    `SKAF_ASSERT_NEXT(a_gain_le_one, ctrl.div_step && status.div_last, gain <= GAIN_ONE)
    // saturating prediction never wraps below the old uncertainty
    `SKAF_ASSERT_NEXT(a_pred_no_wrap, ctrl.p_pred_en, p_reg >= $past(unc_reg))
    // posterior uncertainty never grows past the prediction
    `SKAF_ASSERT_NEXT(a_unc_shrinks, ctrl.unc_wr, unc_reg <= $past(p_reg))
    // correction step never moves farther than the innovation
    `SKAF_ASSERT_SAME(a_corr_bounded, ctrl.ang_sel == ANG_ADD_ERR, prod_mag <= PMAG_W'(emag_reg))

endmodule

// ----- rtl/core/scalar_kalman_angle_filter.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_angle_filter
// One-state Kalman filter fusing gyro rate and accelerometer angle, Q16.16.
// A new transaction is taken only at the wait step, after the last result has
//   gone to the output slot; an update runs the gain divider loop (one quotient
//   bit per cycle, 16 steps).
// Reset: synchronous; angle 0, uncertainty 1.0, noises 66 and 1966, no
//   clearing pass.
// ----------------------------------------------------------------------------
module scalar_kalman_angle_filter
    import skaf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,

    // configuration write port
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [31:0]                   cfg_wdata,

    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic signed [VALUE_WIDTH-1:0] s_angular_rate,
    input  logic signed [VALUE_WIDTH-1:0] s_accel_angle,
    input  logic        [DT_BITS-1:0]     s_time_step,
    input  logic signed [VALUE_WIDTH-1:0] s_seed_angle,

    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_WIDTH-1:0] m_angle_estimate
);

    ucode_t     ctrl;
    dp_status_t status;

    logic                   in_accept;
    logic                   out_free;
    logic [VALUE_WIDTH-1:0] angle;

    logic [31:0]            pn_reg;
    logic [31:0]            mn_reg;

    // output slot: holds a finished result while the sequencer goes back
    // to waiting for the next transaction
    logic                   m_valid_reg;
    logic [VALUE_WIDTH-1:0] m_angle_reg;

    // ready comes straight from the control word of the wait step
    assign s_ready   = ctrl.in_ready;
    assign in_accept = s_valid && s_ready;

    // slot is free when empty or being drained this cycle
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_angle_estimate = m_angle_reg;

    // configuration registers; user keeps writes to filter idle; not enforced
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pn_reg <= PN_RESET;
            mn_reg <= MN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROCESS_NOISE:     pn_reg <= cfg_wdata;
                REG_MEASUREMENT_NOISE: mn_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // result register: loaded at the output step once the slot is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load && out_free) begin
            m_angle_reg <= angle;
        end
    end

    // microprogram: wait, multiply rate, add delta, 16 divide steps,
    // error, multiply correction, add correction, multiply and write
    // uncertainty, output; a seed goes wait, seed, output
    skaf_sequencer u_sequencer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_command (s_command),
        .out_free   (out_free),
        .status     (status),
        .ctrl       (ctrl)
    );

    skaf_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .in_load           (in_accept),
        .angular_rate      (s_angular_rate),
        .accel_angle       (s_accel_angle),
        .time_step         (s_time_step),
        .seed_angle        (s_seed_angle),
        .process_noise     (pn_reg),
        .measurement_noise (mn_reg),
        .status            (status),
        .angle             (angle)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scalar Kalman angle filter. A clocked driver
// feeds IMU transactions from a pending queue, a clocked monitor checks each
// angle estimate against a bit-exact fixed-point filter model kept in step
// with the accepted inputs. Noise settings change between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;
    import skaf_pkg::*;

    // transaction codes on s_command
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_SEED   = 1'b1;

    // fixed-point limits of the filter state
    localparam longint ANGLE_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint ANGLE_MIN = -ANGLE_MAX - 1;
    localparam longint UNC_MAX   = 64'sh0000_0000_FFFF_FFFF;
    localparam longint FX_ONE    = 64'sd65536;
    localparam int     FRAC      = 16;

    // reset values of the filter state and noise registers
    localparam logic [31:0] PN_AT_RESET  = 32'd66;
    localparam logic [31:0] MN_AT_RESET  = 32'd1966;
    localparam logic [31:0] UNC_AT_RESET = 32'd65536;

    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int STALL_LIMIT    = 4000;  // cycles with no transaction at all
    localparam int PHASE_ITEMS    = 225;
    localparam int RANDOM_PHASES  = 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic                          cmd;
        logic signed [VALUE_WIDTH-1:0] rate;
        logic signed [VALUE_WIDTH-1:0] accel;
        logic        [DT_BITS-1:0]     dt;
        logic signed [VALUE_WIDTH-1:0] seed;
    } imu_item_t;

    // ------------------------------------------------------------------------
    // clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [31:0]                   cfg_wdata = '0;

    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic                          s_command      = CMD_UPDATE;
    logic signed [VALUE_WIDTH-1:0] s_angular_rate = '0;
    logic signed [VALUE_WIDTH-1:0] s_accel_angle  = '0;
    logic        [DT_BITS-1:0]     s_time_step    = '0;
    logic signed [VALUE_WIDTH-1:0] s_seed_angle   = '0;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [VALUE_WIDTH-1:0] m_angle_estimate;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    scalar_kalman_angle_filter u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_angular_rate   (s_angular_rate),
        .s_accel_angle    (s_accel_angle),
        .s_time_step      (s_time_step),
        .s_seed_angle     (s_seed_angle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_angle_estimate (m_angle_estimate)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    imu_item_t                     imu_pending_q[$];    // waiting to be driven
    logic signed [VALUE_WIDTH-1:0] angle_expected_q[$]; // one per accepted input

    // filter model state, mirrors the DUT registers
    logic signed [VALUE_WIDTH-1:0] est_angle = '0;
    logic        [VALUE_WIDTH-1:0] est_unc   = UNC_AT_RESET;
    logic        [31:0]            cfg_pn    = PN_AT_RESET;
    logic        [31:0]            cfg_mn    = MN_AT_RESET;

    // traffic shaping, set by the sequencer between phases
    int unsigned src_idle_pct  = 0;
    int unsigned dst_stall_pct = 0;
    int unsigned hold_req      = 0;  // bumped to ask the monitor for a hold-off
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;

    int unsigned err_count    = 0;
    int unsigned stall_cycles = 0;

    // ------------------------------------------------------------------------
    // filter model
    // ------------------------------------------------------------------------
    function automatic longint clamp_angle(input longint v);
        if (v > ANGLE_MAX) return ANGLE_MAX;
        if (v < ANGLE_MIN) return ANGLE_MIN;
        return v;
    endfunction

    // Advance the model by one accepted transaction, return the new estimate.
    function automatic logic signed [VALUE_WIDTH-1:0] kalman_step(input imu_item_t it);
        longint ang, rate, acc, dt, rmag, delta, pn, mn;
        longint p, d, k, r, err, emag, corr;
        if (it.cmd == CMD_SEED) begin
            ang = it.seed;
        end else begin
            rate = it.rate;
            acc  = it.accel;
            dt   = it.dt;
            pn   = cfg_pn;
            mn   = cfg_mn;

            // predict: rate * dt truncated toward zero
            rmag  = (rate < 0) ? -rate : rate;
            delta = (rmag * dt) >> DT_BITS;
            ang   = est_angle;
            ang   = clamp_angle(ang + ((rate < 0) ? -delta : delta));

            p = est_unc;
            p = p + pn;
            if (p > UNC_MAX) p = UNC_MAX;

            // gain by restoring division, zero when the denominator is zero
            d = p + mn;
            if (d == 0) begin
                k = 0;
            end else begin
                k = (p >= d) ? 1 : 0;
                r = (k != 0) ? p - d : p;
                for (int i = 0; i < FRAC; i++) begin
                    r = r << 1;
                    k = k << 1;
                    if (r >= d) begin
                        r = r - d;
                        k = k | 1;
                    end
                end
            end

            // correct toward the accelerometer angle
            err  = acc - ang;
            emag = (err < 0) ? -err : err;
            corr = (emag * k) >> FRAC;
            ang  = clamp_angle(ang + ((err < 0) ? -corr : corr));

            est_unc = VALUE_WIDTH'((p * (FX_ONE - k)) >> FRAC);
        end
        est_angle = VALUE_WIDTH'(ang);
        return est_angle;
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers queued transactions, predicts on each acceptance
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive
        imu_item_t acc_item;
        imu_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                acc_item.cmd   = s_command;
                acc_item.rate  = s_angular_rate;
                acc_item.accel = s_accel_angle;
                acc_item.dt    = s_time_step;
                acc_item.seed  = s_seed_angle;
                angle_expected_q.push_back(kalman_step(acc_item));
            end
            // a held transaction stays put until accepted
            if (!s_valid || s_ready) begin
                if (imu_pending_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                    nxt = imu_pending_q.pop_front();
                    s_valid        <= 1'b1;
                    s_command      <= nxt.cmd;
                    s_angular_rate <= nxt.rate;
                    s_accel_angle  <= nxt.accel;
                    s_time_step    <= nxt.dt;
                    s_seed_angle   <= nxt.seed;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks results, drives m_ready with stalls and hold-offs
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        logic signed [VALUE_WIDTH-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (angle_expected_q.size() == 0) begin
                    if (err_count < MAX_REPORTS)
                        $display("unexpected result: angle_estimate %0d", m_angle_estimate);
                    err_count++;
                end else begin
                    want = angle_expected_q.pop_front();
                    if (m_angle_estimate !== want) begin
                        if (err_count < MAX_REPORTS)
                            $display("angle_estimate mismatch: expected %0d, got %0d",
                                     want, m_angle_estimate);
                        err_count++;
                    end
                end
            end
            // long hold-off lets the block back up into its input
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= dst_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: work outstanding but no transaction on either side
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (imu_pending_q.size() == 0 && !s_valid && angle_expected_q.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // sequencer helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_PROCESS_NOISE)
            cfg_pn = val;
        else if (idx == REG_MEASUREMENT_NOISE)
            cfg_mn = val;
    endtask

    task automatic set_noise(input logic [31:0] pn, input logic [31:0] mn);
        write_reg(REG_PROCESS_NOISE, pn);
        write_reg(REG_MEASUREMENT_NOISE, mn);
        @(negedge aclk);
    endtask

    // returns at a falling edge once the block has nothing in flight
    task automatic drain();
        while (imu_pending_q.size() != 0 || s_valid || angle_expected_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic push_update(input logic signed [VALUE_WIDTH-1:0] rate,
                               input logic signed [VALUE_WIDTH-1:0] accel,
                               input logic [DT_BITS-1:0] dt);
        imu_item_t it;
        it.cmd   = CMD_UPDATE;
        it.rate  = rate;
        it.accel = accel;
        it.dt    = dt;
        it.seed  = $urandom;  // ignored on update
        imu_pending_q.push_back(it);
    endtask

    task automatic push_seed(input logic signed [VALUE_WIDTH-1:0] angle);
        imu_item_t it;
        it.cmd   = CMD_SEED;
        it.rate  = $urandom;  // ignored on seed
        it.accel = $urandom;
        it.dt    = DT_BITS'($urandom);
        it.seed  = angle;
        imu_pending_q.push_back(it);
    endtask

    // mostly sensor-like magnitudes, sometimes anything at all
    function automatic logic signed [VALUE_WIDTH-1:0] pick_value(input int unsigned lim);
        int v;
        if ($urandom_range(9, 0) < 3) return $urandom;
        v = int'($urandom_range(lim, 0));
        if ($urandom_range(1, 0) == 1) v = -v;
        return v;
    endfunction

    function automatic imu_item_t random_item();
        imu_item_t it;
        it.cmd   = ($urandom_range(99, 0) < 15) ? CMD_SEED : CMD_UPDATE;
        it.rate  = pick_value(32'h0040_0000);
        it.accel = pick_value(32'h0040_0000);
        it.dt    = ($urandom_range(9, 0) < 7) ? DT_BITS'($urandom_range(3000, 0))
                                              : DT_BITS'($urandom);
        it.seed  = pick_value(32'h0040_0000);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    initial begin : sequencer
        logic [31:0] pn, mn;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset noise settings: trivial step, both range ends
        push_update(32'sd0, 32'sd0, 16'd0);
        push_seed(32'sh7FFF_FFFF);
        push_update(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF);  // pins high
        push_seed(32'sh8000_0000);
        push_update(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF);  // pins low
        push_update(32'sd0, 32'sh7FFF_FFFF, 16'd0);             // largest error
        push_update(32'sh7FFF_FFFF, 32'sh8000_0000, 16'h8000);
        push_seed(32'sd0);
        push_update(32'sh0003_0000, 32'sh0001_0000, 16'h0147);
        drain();

        // no noise at all: gain of one empties P, then a zero denominator
        set_noise(32'd0, 32'd0);
        push_update(32'sh0000_1000, 32'sh1234_5678, 16'h0100);
        push_update(32'sd0, 32'sh7FFF_FFFF, 16'h0010);
        push_seed(32'shFFFF_0000);
        push_update(32'shFFFF_FFFF, 32'sh8000_0000, 16'd1);
        drain();

        // saturating process noise, predicted uncertainty pinned at its top
        set_noise(32'hFFFF_FFFF, 32'd1);
        push_update(32'sh0001_0000, 32'sh0100_0000, 16'h4000);
        push_update(32'shFFFF_0000, 32'shFF00_0000, 16'hFFFF);
        push_update(32'sd0, 32'sd0, 16'd0);
        drain();

        set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_update(32'sh0002_0000, 32'sh0050_0000, 16'h1000);
        push_update(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF);
        drain();

        set_noise(32'd0, 32'hFFFF_FFFF);
        push_update(32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0001);
        push_update(32'sh0000_0100, 32'sh0000_0200, 16'h0200);
        drain();

        // random phases, one noise setting and one traffic pattern each
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin pn = $urandom_range(4000, 0); mn = $urandom_range(4000, 0); end
                1: begin pn = 32'd0;                   mn = $urandom_range(4000, 0); end
                2: begin pn = $urandom;                mn = $urandom;                end
                3: begin pn = $urandom_range(4000, 0); mn = 32'd0;                   end
                4: begin pn = 32'hFFFF_FFFF;           mn = $urandom_range(4000, 0); end
                5: begin pn = $urandom_range(4000, 0); mn = 32'hFFFF_FFFF;           end
                6: begin pn = $urandom_range(200, 0);  mn = $urandom_range(60000, 0); end
                default: begin pn = $urandom;          mn = $urandom_range(4000, 0); end
            endcase
            set_noise(pn, mn);

            case (ph % 4)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 78; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 78; end
                default: begin src_idle_pct = 22; dst_stall_pct = 22; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
                imu_pending_q.push_back(random_item());
            // back-to-back phases also get a long receiver hold-off
            if (ph % 4 == 0)
                hold_req++;
            drain();
        end

        // let any stray result show up before the verdict
        repeat (40) @(posedge aclk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
